// File: sv/pru_pkg.sv
`default_nettype none
package pru_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam logic [3:0] MAX_SCALE = 4'd8;

  localparam int PIX_W = 24;
  localparam int SCALE_W = 4;
  localparam int WIDTH_W = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH = 2'd1;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             row_end;
    logic [1:0]       pad_bytes;
    logic             last;
  } out_item_t;

  // one accepted item as handed to the output stage
  typedef struct packed {
    logic               is_tick;
    logic [PIX_W-1:0]   px;
    logic [SCALE_W-1:0] reps;
    logic               row_end;
    logic [1:0]         pad;
  } job_t;

endpackage
`default_nettype wire

// File: sv/pru_line_mem.sv
`default_nettype none
module pru_line_mem #(
  parameter int DEPTH = pru_pkg::DEF_MAX_WIDTH,
  parameter int AW = 10
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic [pru_pkg::PIX_W-1:0] wr_data,
  input  wire logic                     rd_en,
  input  wire logic [AW-1:0]            rd_addr,
  output logic      [pru_pkg::PIX_W-1:0] rd_q
);

  logic [pru_pkg::PIX_W-1:0] mem [DEPTH];
  logic [pru_pkg::PIX_W-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_q = rd_q_r;

endmodule
`default_nettype wire

// File: sv/pru_ctrl.sv
`default_nettype none
module pru_ctrl #(
  parameter int MAX_WIDTH = pru_pkg::DEF_MAX_WIDTH,
  parameter int AW = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  input  wire logic [pru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pru_pkg::WIDTH_W-1:0]   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire pru_pkg::in_item_t             in_item,
  output logic                               job_valid,
  input  wire logic                          job_ready,
  output pru_pkg::job_t                      job,
  output logic                               wr_en,
  output logic [AW-1:0]                      wr_addr,
  output logic [pru_pkg::PIX_W-1:0]          wr_data,
  output logic                               rd_en,
  output logic [AW-1:0]                      rd_addr
);

  localparam int CMPW = (AW + 1 > pru_pkg::WIDTH_W) ? AW + 1 : pru_pkg::WIDTH_W;

  logic [pru_pkg::SCALE_W-1:0] scale_r;
  logic [pru_pkg::WIDTH_W-1:0] width_r;
  logic                        phase_r, phase_nxt;
  logic [AW-1:0]               fill_col_r, fill_col_nxt;
  logic [AW-1:0]               rep_col_r, rep_col_nxt;
  logic [pru_pkg::SCALE_W-1:0] rep_row_r, rep_row_nxt;
  logic [pru_pkg::SCALE_W-1:0] rep_sub_r, rep_sub_nxt;

  logic [pru_pkg::SCALE_W-1:0] s_eff;
  logic [CMPW-1:0]             w_eff;
  logic [3:0]                  pad_prod;
  logic [1:0]                  pad;
  logic                        acc, act_pix, act_tick;
  logic                        fill_end, rep_end, sub_wrap, row_done;

  always_comb begin
    if (scale_r == '0) begin
      s_eff = pru_pkg::SCALE_W'(1);
    end else if (scale_r > pru_pkg::MAX_SCALE) begin
      s_eff = pru_pkg::MAX_SCALE;
    end else begin
      s_eff = scale_r;
    end
    if (width_r == '0) begin
      w_eff = CMPW'(1);
    end else if (CMPW'(width_r) > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = CMPW'(width_r);
    end
  end

  // 3*w*s bytes; pad to a multiple of 4 is (w*s) mod 4
  assign pad_prod = w_eff[1:0] * s_eff[1:0];
  assign pad      = pad_prod[1:0];

  assign in_ready = job_ready;
  assign acc      = in_valid && in_ready;
  assign act_pix  = acc && (in_item.op == pru_pkg::OP_PIXEL) && !phase_r;
  assign act_tick = acc && (in_item.op == pru_pkg::OP_TICK) && phase_r;

  assign fill_end = (CMPW'(fill_col_r) + CMPW'(1)) >= w_eff;
  assign rep_end  = (CMPW'(rep_col_r) + CMPW'(1)) >= w_eff;
  assign sub_wrap = ({1'b0, rep_sub_r} + 5'd1) >= {1'b0, s_eff};
  assign row_done = ({1'b0, rep_row_r} + 5'd2) >= {1'b0, s_eff};

  assign wr_en   = act_pix;
  assign wr_addr = fill_col_r;
  assign wr_data = in_item.pixel_in;
  assign rd_en   = act_tick;
  assign rd_addr = rep_col_r;

  always_comb begin
    phase_nxt    = phase_r;
    fill_col_nxt = fill_col_r;
    rep_col_nxt  = rep_col_r;
    rep_row_nxt  = rep_row_r;
    rep_sub_nxt  = rep_sub_r;
    job_valid    = act_pix || act_tick;
    job.is_tick  = act_tick;
    job.px       = in_item.pixel_in;
    job.reps     = act_tick ? '0 : s_eff - pru_pkg::SCALE_W'(1);
    job.row_end  = act_tick ? (sub_wrap && rep_end) : fill_end;
    job.pad      = pad;
    if (act_pix) begin
      if (fill_end) begin
        fill_col_nxt = '0;
        if (s_eff > pru_pkg::SCALE_W'(1)) begin
          phase_nxt   = 1'b1;
          rep_col_nxt = '0;
          rep_row_nxt = '0;
          rep_sub_nxt = '0;
        end
      end else begin
        fill_col_nxt = fill_col_r + AW'(1);
      end
    end
    if (act_tick) begin
      if (sub_wrap) begin
        rep_sub_nxt = '0;
        if (rep_end) begin
          rep_col_nxt = '0;
          if (row_done) begin
            rep_row_nxt = '0;
            phase_nxt   = 1'b0;
          end else begin
            rep_row_nxt = rep_row_r + pru_pkg::SCALE_W'(1);
          end
        end else begin
          rep_col_nxt = rep_col_r + AW'(1);
        end
      end else begin
        rep_sub_nxt = rep_sub_r + pru_pkg::SCALE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r    <= pru_pkg::SCALE_W'(1);
      width_r    <= pru_pkg::WIDTH_W'(1);
      phase_r    <= 1'b0;
      fill_col_r <= '0;
      rep_col_r  <= '0;
      rep_row_r  <= '0;
      rep_sub_r  <= '0;
    end else begin
      if (cfg_valid && (cfg_index == pru_pkg::REG_SCALE)) begin
        scale_r <= cfg_data[pru_pkg::SCALE_W-1:0];
      end
      if (cfg_valid && (cfg_index == pru_pkg::REG_IN_WIDTH)) begin
        width_r <= cfg_data;
      end
      phase_r    <= phase_nxt;
      fill_col_r <= fill_col_nxt;
      rep_col_r  <= rep_col_nxt;
      rep_row_r  <= rep_row_nxt;
      rep_sub_r  <= rep_sub_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/pru_out.sv
`default_nettype none
module pru_out (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      job_valid,
  output logic                           job_ready,
  input  wire pru_pkg::job_t             job,
  input  wire logic [pru_pkg::PIX_W-1:0] rd_q,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output pru_pkg::out_item_t             out_item
);

  logic                        valid_r;
  pru_pkg::job_t               job_r;
  logic [pru_pkg::SCALE_W-1:0] cnt_r;
  logic                        last, fire;

  assign last      = job_r.is_tick || (cnt_r == '0);
  assign fire      = valid_r && out_ready;
  assign job_ready = !valid_r || (fire && last);
  assign out_valid = valid_r;

  assign out_item.pixel_out = job_r.is_tick ? rd_q : job_r.px;
  assign out_item.row_end   = last && job_r.row_end;
  assign out_item.pad_bytes = (last && job_r.row_end) ? job_r.pad : 2'd0;
  assign out_item.last      = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (job_ready) begin
      valid_r <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      job_r <= job;
      cnt_r <= job.reps;
    end else if (fire && !last) begin
      cnt_r <= cnt_r - pru_pkg::SCALE_W'(1);
    end
  end

endmodule
`default_nettype wire

// File: sv/pixel_replicate_upscaler.sv
// Integer nearest-neighbor upscaler for 24-bit RGB rows. Pixel items (op 0)
// fill the line store and each gives scale results, one per cycle while out_ready
// is high; after the row, tick items (op 1) replay the stored row scale-1 more
// times, one result per tick, one tick per cycle while out_ready is high (one
// line-store read each). Results start the cycle after the item is accepted; a new
// item is taken in the cycle the last result of the previous one leaves. Items
// of the wrong kind for the current phase are taken and give no result. The last
// pixel of each output row has row_end set and pad_bytes for 4-byte BMP row
// alignment. The config port is always ready; write it only while the block is idle.
`default_nettype none
module pixel_replicate_upscaler #(
  parameter int MAX_WIDTH = pru_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pru_pkg::WIDTH_W-1:0]   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire pru_pkg::in_item_t             in_item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output pru_pkg::out_item_t                 out_item
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic                      job_valid, job_ready;
  pru_pkg::job_t             job;
  logic                      wr_en, rd_en;
  logic [AW-1:0]             wr_addr, rd_addr;
  logic [pru_pkg::PIX_W-1:0] wr_data, rd_q;

  assign cfg_ready = 1'b1;

  pru_ctrl #(
    .MAX_WIDTH(MAX_WIDTH),
    .AW       (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .job_valid(job_valid),
    .job_ready(job_ready),
    .job      (job),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr)
  );

  pru_line_mem #(
    .DEPTH(MAX_WIDTH),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_q   (rd_q)
  );

  pru_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(job_valid),
    .job_ready(job_ready),
    .job      (job),
    .rd_q     (rd_q),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule
`default_nettype wire

// File: bench/replicate_checker.sv
module replicate_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pru_pkg::WIDTH_W-1:0]   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  pru_pkg::in_item_t             in_item,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  pru_pkg::out_item_t            out_item,
  output int                            fail_count,
  output int                            pending,
  output logic                          replaying,
  output logic                          mid_row,
  output int                            results_checked,
  output int                            rows_seen,
  output int                            ignored_items
);
  import pru_pkg::*;

  localparam int ROW_ALIGN = 4;
  localparam int MAX_REPORTS = 10;

  logic [PIX_W-1:0]   line_mem [DEF_MAX_WIDTH];
  logic [SCALE_W-1:0] scale_q;
  logic [WIDTH_W-1:0] width_q;
  int unsigned        fill_col;
  int unsigned        rep_row;
  int unsigned        rep_col;
  int unsigned        rep_sub;
  out_item_t          expected_q [$];

  function automatic int unsigned eff_scale();
    if (scale_q == '0) return 1;
    if (scale_q > MAX_SCALE) return MAX_SCALE;
    return scale_q;
  endfunction

  function automatic int unsigned eff_width();
    if (width_q == '0) return 1;
    if (width_q > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return width_q;
  endfunction

  // zero bytes needed to round a row of w*s 3-byte pixels up to a multiple of 4 bytes
  function automatic logic [1:0] bmp_pad(int unsigned w, int unsigned s);
    return 2'((ROW_ALIGN - (w * s * 3) % ROW_ALIGN) % ROW_ALIGN);
  endfunction

  function automatic out_item_t make_result(logic [PIX_W-1:0] px, logic ends,
                                            logic [1:0] pad, logic fin);
    out_item_t r;
    r.pixel_out = px;
    r.row_end   = ends;
    r.pad_bytes = ends ? pad : 2'd0;
    r.last      = fin;
    return r;
  endfunction

  task automatic replicate_item(input in_item_t it);
    int unsigned      s;
    int unsigned      w;
    int unsigned      col;
    logic [1:0]       pad;
    logic [PIX_W-1:0] px;
    logic             row_done;
    s = eff_scale();
    w = eff_width();
    pad = bmp_pad(w, s);
    row_done = 1'b0;
    if (it.op == OP_PIXEL) begin
      if (replaying) begin
        ignored_items++;
        return;
      end
      col = fill_col % DEF_MAX_WIDTH;
      line_mem[col] = it.pixel_in;
      row_done = (col + 1 >= w);
      for (int unsigned k = 0; k < s; k++) begin
        expected_q.push_back(make_result(it.pixel_in, row_done && (k + 1 == s), pad,
                                         k + 1 == s));
      end
      if (row_done) begin
        fill_col = 0;
        if (s > 1) begin
          replaying = 1'b1;
          rep_row = 0;
          rep_col = 0;
          rep_sub = 0;
        end
      end else begin
        fill_col = col + 1;
      end
    end else begin
      if (!replaying) begin
        ignored_items++;
        return;
      end
      col = rep_col % DEF_MAX_WIDTH;
      px = line_mem[col];
      if (rep_sub + 1 >= s) begin
        rep_sub = 0;
        if (col + 1 >= w) begin
          row_done = 1'b1;
          rep_col = 0;
          if (rep_row + 2 >= s) begin
            rep_row = 0;
            replaying = 1'b0;
          end else begin
            rep_row++;
          end
        end else begin
          rep_col = col + 1;
        end
      end else begin
        rep_sub++;
      end
      expected_q.push_back(make_result(px, row_done, pad, 1'b1));
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: unexpected result px %06h row_end %b pad %0d last %b", $time,
                 got.pixel_out, got.row_end, got.pad_bytes, got.last);
      return;
    end
    want = expected_q.pop_front();
    if (got.pixel_out !== want.pixel_out || got.row_end !== want.row_end ||
        got.pad_bytes !== want.pad_bytes || got.last !== want.last) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: mismatch, expected px %06h row_end %b pad %0d last %b, got px %06h row_end %b pad %0d last %b",
                 $time, want.pixel_out, want.row_end, want.pad_bytes, want.last,
                 got.pixel_out, got.row_end, got.pad_bytes, got.last);
    end else begin
      results_checked++;
      if (got.row_end) rows_seen++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_q.delete();
      scale_q = 4'd1;
      width_q = 11'd1;
      fill_col = 0;
      rep_row = 0;
      rep_col = 0;
      rep_sub = 0;
      replaying = 1'b0;
      fail_count = 0;
      results_checked = 0;
      rows_seen = 0;
      ignored_items = 0;
    end else begin
      if (out_valid && out_ready) check_result(out_item);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SCALE) scale_q = cfg_data[SCALE_W-1:0];
        else if (cfg_index == REG_IN_WIDTH) width_q = cfg_data;
      end
      if (in_valid && in_ready) replicate_item(in_item);
    end
    pending = expected_q.size();
    mid_row = (fill_col != 0);
  end

endmodule

// File: bench/pixel_replicate_upscaler_test.sv
module pixel_replicate_upscaler_test;
  import pru_pkg::*;

  localparam int RANDOM_ITEMS = 50;
  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_LIMIT = 500;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_SPARSE} rx_mode_e;

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WIDTH_W-1:0] cfg_data;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_item;

  int   fail_count;
  int   pending;
  logic replaying;
  logic mid_row;
  int   results_checked;
  int   rows_seen;
  int   ignored_items;

  int burst_left;
  int useful_items;
  int reg_writes;

  pixel_replicate_upscaler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  replicate_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item),
    .fail_count      (fail_count),
    .pending         (pending),
    .replaying       (replaying),
    .mid_row         (mid_row),
    .results_checked (results_checked),
    .rows_seen       (rows_seen),
    .ignored_items   (ignored_items)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rx_mode_e mode;
    out_ready = 1'b0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 2));
      repeat ($urandom_range(16, 64)) begin
        @(negedge clk);
        case (mode)
          RX_FREE:   out_ready <= 1'b1;
          RX_RANDOM: out_ready <= ($urandom_range(0, 1) == 1);
          default:   out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Watchdog: %0d idle cycles, %0d results outstanding", quiet, pending);
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [WIDTH_W-1:0] pick_scale();
    if ($urandom_range(0, 15) == 0) return '0;
    return WIDTH_W'($urandom_range(1, 4));
  endfunction

  function automatic logic [WIDTH_W-1:0] pick_width();
    if ($urandom_range(0, 15) == 0) return '0;
    return WIDTH_W'($urandom_range(1, 7));
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic kind, input logic [PIX_W-1:0] px);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 10);
    end
    in_item <= in_item_t'{op: kind, pixel_in: px};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  // registers change only with no result outstanding
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIDTH_W-1:0] val);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  // one input row plus its replay, with stray items of the wrong kind mixed in
  task automatic send_row(input logic retune);
    logic kind;
    logic started;
    started = 1'b0;
    while (!started || mid_row || replaying) begin
      if (retune && $urandom_range(0, 39) == 0) begin
        if (!replaying) write_reg(REG_IN_WIDTH, pick_width());
        else write_reg(REG_SCALE, pick_scale());
      end
      if (replaying) kind = ($urandom_range(0, 11) == 0) ? OP_PIXEL : OP_TICK;
      else kind = ($urandom_range(0, 11) == 0) ? OP_TICK : OP_PIXEL;
      if ((kind == OP_PIXEL) != replaying) begin
        useful_items++;
        if (kind == OP_PIXEL) started = 1'b1;
      end
      send_item(kind, rand_pixel());
    end
  endtask

  task automatic close_row();
    while (mid_row || replaying) begin
      if (replaying) send_item(OP_TICK, rand_pixel());
      else send_item(OP_PIXEL, rand_pixel());
    end
  endtask

  task automatic wide_row(input int unsigned s, input int unsigned w);
    write_reg(REG_SCALE, WIDTH_W'(s));
    write_reg(REG_IN_WIDTH, WIDTH_W'(w));
    send_row(1'b0);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_SCALE;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    burst_left = 0;
    useful_items = 0;
    reg_writes = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: scale 1, one pixel per row
    send_item(OP_TICK, 24'h000000);
    send_item(OP_PIXEL, 24'h000000);
    send_item(OP_PIXEL, 24'hFFFFFF);

    write_reg(REG_SCALE, '0);
    write_reg(REG_IN_WIDTH, '0);
    send_item(OP_PIXEL, 24'h5A5AA5);

    // pixel during replay, then scale cut short mid-replay
    write_reg(REG_SCALE, 11'd3);
    write_reg(REG_IN_WIDTH, 11'd2);
    send_item(OP_PIXEL, 24'h000000);
    send_item(OP_PIXEL, 24'hFFFFFF);
    send_item(OP_PIXEL, 24'h123456);
    repeat (4) send_item(OP_TICK, 24'hFFFFFF);
    write_reg(REG_SCALE, 11'd2);
    close_row();

    // width cut below the fill position ends the row at the next pixel
    write_reg(REG_IN_WIDTH, 11'd4);
    send_item(OP_PIXEL, 24'hA5A5A5);
    send_item(OP_PIXEL, 24'h5A5A5A);
    write_reg(REG_IN_WIDTH, 11'd1);
    send_item(OP_PIXEL, 24'hC3C3C3);
    close_row();

    useful_items = 0;
    while (useful_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) write_reg(REG_SCALE, pick_scale());
      if ($urandom_range(0, 2) == 0) write_reg(REG_IN_WIDTH, pick_width());
      send_row(1'b1);
    end

    wide_row(15, 1);

    // width above the maximum saturates, then a cut ends the row
    write_reg(REG_SCALE, 11'd1);
    write_reg(REG_IN_WIDTH, 11'd2047);
    repeat (3) send_item(OP_PIXEL, rand_pixel());
    write_reg(REG_IN_WIDTH, 11'd1);
    close_row();

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d results in %0d output rows; %0d stray items dropped by the block",
             results_checked, rows_seen, ignored_items);
    $display("%0d register writes, scale 0 to 15 and width 0 to 2047, some mid-row",
             reg_writes);
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
sv/pru_pkg.sv
sv/pru_line_mem.sv
sv/pru_ctrl.sv
sv/pru_out.sv
sv/pixel_replicate_upscaler.sv
bench/replicate_checker.sv
bench/pixel_replicate_upscaler_test.sv
